// File: hw/rtl/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

  // Field widths fixed by the port list
  localparam int unsigned COORD_W = 8;
  localparam int unsigned CELL_W  = 3;
  localparam int unsigned HEAD_W  = 2;
  localparam int unsigned STEP_W  = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Widest color count a cell can hold
  localparam int unsigned CELL_COLORS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TURN_MASK = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLORS    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 8'd3;

  // Register reset values
  localparam logic [7:0] RST_TURN_MASK = 8'd20;
  localparam logic [3:0] RST_COLORS    = 4'd7;
  localparam logic [7:0] RST_START_X   = 8'd128;
  localparam logic [7:0] RST_START_Y   = 8'd128;

  // Headings
  localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd3;

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [HEAD_W-1:0] head_t;

endpackage

// File: hw/rtl/multicolor_turmite_step.sv
`timescale 1ns / 1ps

// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// input     | start, busy, in_advance                 | beat on start && !busy
// result    | out_valid, out_painted_*, out_ant_*,    | one-cycle strobe, no stall
//           | out_heading, out_steps_taken            |
// config    | cfg_valid, cfg_ready, cfg_index,        | beat on cfg_valid && cfg_ready
//           | cfg_data                                | ready low while a beat is taken
//
// For each beat the cell under the ant is read from the grid RAM at the accept edge;
// in the execute state after it the new color is written back and the ant moves (both
// only if in_advance was set) and the result registers load; the result strobe shows
// in the following cycle, when the next beat can already be accepted.
// After reset the grid RAM is cleared one cell per cycle, all 2**(clog2(GRID_WIDTH) +
// clog2(GRID_HEIGHT)) cells (65536 at the defaults), with busy held high.
// The receiver cannot stall: results are strobed once and never held.

module multicolor_turmite_step #(
  parameter int unsigned GRID_WIDTH  = 256,
  parameter int unsigned GRID_HEIGHT = 256,
  parameter int unsigned MAX_COLORS  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_advance,
  // result channel
  output logic                              out_valid,
  output logic [mts_pkg::COORD_W-1:0]       out_painted_x,
  output logic [mts_pkg::COORD_W-1:0]       out_painted_y,
  output logic [mts_pkg::CELL_W-1:0]        out_painted_color,
  output logic [mts_pkg::COORD_W-1:0]       out_ant_x_now,
  output logic [mts_pkg::COORD_W-1:0]       out_ant_y_now,
  output logic [mts_pkg::HEAD_W-1:0]        out_heading,
  output logic [mts_pkg::STEP_W-1:0]        out_steps_taken,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mts_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned CW = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
  localparam int unsigned RW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int unsigned AW = CW + RW;
  localparam int unsigned MEM_DEPTH = 1 << AW;
  localparam int unsigned COLOR_LIM =
    (MAX_COLORS > mts_pkg::CELL_COLORS) ? mts_pkg::CELL_COLORS : MAX_COLORS;
  localparam logic [CW-1:0] LAST_COL = CW'(GRID_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);
  localparam logic [3:0]    LIM4     = 4'(COLOR_LIM);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  // clamp of an 8-bit start coordinate into the grid
  function automatic logic [CW-1:0] clamp_col(input logic [7:0] v);
    return (32'(v) >= GRID_WIDTH) ? LAST_COL : CW'(v);
  endfunction

  function automatic logic [RW-1:0] clamp_row(input logic [7:0] v);
    return (32'(v) >= GRID_HEIGHT) ? LAST_ROW : RW'(v);
  endfunction

  logic [1:0]                      state_r, state_nxt;
  logic [AW-1:0]                   clr_addr_r;
  logic                            adv_r;

  logic [7:0]                      mask_r;
  logic [3:0]                      colors_r;

  logic [CW-1:0]                   col_r, col_nxt;
  logic [RW-1:0]                   row_r, row_nxt;
  mts_pkg::head_t                  head_r, head_nxt;
  logic [mts_pkg::STEP_W-1:0]      steps_r, steps_nxt;

  mts_pkg::cell_t                  mem_q [0:MEM_DEPTH-1];
  mts_pkg::cell_t                  rd_data_r;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  mts_pkg::cell_t                  mem_wdata;

  logic [3:0]                      n_active;
  logic [3:0]                      next_color;
  mts_pkg::cell_t                  new_color;
  logic                            accept;
  logic                            cfg_beat;

  logic                            out_valid_r;
  logic [mts_pkg::COORD_W-1:0]     px_r, py_r, ax_r, ay_r;
  mts_pkg::cell_t                  pc_r;
  mts_pkg::head_t                  oh_r;
  logic [mts_pkg::STEP_W-1:0]      os_r;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  // no config write while a beat executes or in the cycle one is taken
  assign cfg_ready = (state_r != ST_EXEC) && !accept;
  assign cfg_beat  = cfg_valid && cfg_ready;

  // active color count, clamped to [2, limit]
  always_comb begin
    if (colors_r < 4'd2) begin
      n_active = 4'd2;
    end else if (colors_r > LIM4) begin
      n_active = LIM4;
    end else begin
      n_active = colors_r;
    end
    next_color = {1'b0, rd_data_r} + 4'd1;
    new_color  = (next_color >= n_active) ? '0 : next_color[mts_pkg::CELL_W-1:0];
  end

  // step logic: turn, move, count; start writes place the ant at once
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    head_nxt  = head_r;
    steps_nxt = steps_r;
    if (state_r == ST_EXEC && adv_r) begin
      head_nxt = mask_r[rd_data_r] ? head_r + 2'd1 : head_r - 2'd1;
      case (head_nxt)
        mts_pkg::HEAD_UP:    row_nxt = (row_r != '0) ? row_r - RW'(1) : row_r;
        mts_pkg::HEAD_RIGHT: col_nxt = (col_r != LAST_COL) ? col_r + CW'(1) : col_r;
        mts_pkg::HEAD_DOWN:  row_nxt = (row_r != LAST_ROW) ? row_r + RW'(1) : row_r;
        default:             col_nxt = (col_r != '0) ? col_r - CW'(1) : col_r;
      endcase
      if (steps_r != '1) begin
        steps_nxt = steps_r + 32'd1;
      end
    end
    if (cfg_beat) begin
      case (cfg_index)
        mts_pkg::REG_START_X: col_nxt = clamp_col(cfg_data);
        mts_pkg::REG_START_Y: row_nxt = clamp_row(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:  if (start) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      adv_r <= in_advance;
    end
  end

  // configuration registers and ant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= mts_pkg::RST_TURN_MASK;
      colors_r <= mts_pkg::RST_COLORS;
      col_r    <= clamp_col(mts_pkg::RST_START_X);
      row_r    <= clamp_row(mts_pkg::RST_START_Y);
      head_r   <= mts_pkg::HEAD_UP;
      steps_r  <= '0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      head_r  <= head_nxt;
      steps_r <= steps_nxt;
      if (cfg_beat) begin
        case (cfg_index)
          mts_pkg::REG_TURN_MASK: mask_r   <= cfg_data;
          mts_pkg::REG_COLORS:    colors_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // grid RAM port mux: clearing pass or write-back of the stepped cell
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {row_r, col_r};
    mem_wdata = new_color;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == ST_EXEC && adv_r) begin
      mem_we = 1'b1;
    end
  end

  // grid RAM, read of the cell under the ant every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_q[{row_r, col_r}];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      px_r <= mts_pkg::COORD_W'(col_r);
      py_r <= mts_pkg::COORD_W'(row_r);
      pc_r <= adv_r ? new_color : rd_data_r;
      ax_r <= mts_pkg::COORD_W'(col_nxt);
      ay_r <= mts_pkg::COORD_W'(row_nxt);
      oh_r <= head_nxt;
      os_r <= steps_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_painted_x     = px_r;
  assign out_painted_y     = py_r;
  assign out_painted_color = pc_r;
  assign out_ant_x_now     = ax_r;
  assign out_ant_y_now     = ay_r;
  assign out_heading       = oh_r;
  assign out_steps_taken   = os_r;

endmodule

// File: hw/rtl/mts_checker.sv
`timescale 1ns / 1ps

module mts_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           in_advance,
  input logic                           out_valid,
  input logic [mts_pkg::STEP_W-1:0]     out_steps_taken,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // an accepted beat yields its result strobe after the execute state
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing after accepted beat");

  // the block is busy in the cycle after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepted beat");

  // results are single-cycle strobes
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a step without advance leaves the counter unchanged
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_advance && $past(out_valid)) |-> ##2
      (out_steps_taken == $past(out_steps_taken, 2)))
    else $error("step count moved on a report-only beat");

  // the configuration port is open whenever the block is idle and no beat is offered
  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start && cfg_valid) |-> cfg_ready)
    else $error("config write refused while idle");

endmodule

bind multicolor_turmite_step mts_checker u_mts_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_advance      (in_advance),
  .out_valid       (out_valid),
  .out_steps_taken (out_steps_taken),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready)
);
